@@ rtl/target_track_keeper_core_defines.svh @@
// Assertion macros for the target track keeper core
`ifndef TARGET_TRACK_KEEPER_CORE_DEFINES_SVH
`define TARGET_TRACK_KEEPER_CORE_DEFINES_SVH
`ifndef SYNTH
`define TTK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define TTK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define TTK_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TTK_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/ttk_pkg.sv @@
// ----------------------------------------------------------------------------
// ttk_pkg
// Shared types, constants and the CORDIC angle table for the track keeper.
// ----------------------------------------------------------------------------
package ttk_pkg;
	localparam int HistDepth = 64;
	localparam int HistIdxW = $clog2(HistDepth);
	localparam int HistCntW = $clog2(HistDepth + 1);
	localparam int CordicSteps = 16;
	localparam int StepW = $clog2(CordicSteps);
	localparam int AccW = 40;
	localparam int LostHeadingLimit = 10;
	localparam logic signed [15:0] HalfTurnQ7 = 16'sd23040;
	localparam logic signed [AccW-1:0] HalfTurnQ16 = 40'sd11796480;

	typedef enum logic [1:0] {
		FUNC_SELECT = 2'd0,
		FUNC_DETECT = 2'd1,
		FUNC_MISS = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		REG_HIST_LEN = 3'd0,
		REG_DIR_WIN = 3'd1,
		REG_QUICK = 3'd2,
		REG_SLOW = 3'd3,
		REG_REST = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_FETCH,
		ST_CORDIC,
		ST_ROUND,
		ST_OUT
	} state_t;

	// per-cell control, broadcast along the chain
	typedef struct packed {
		logic wr;
		logic [HistIdxW-1:0] wr_idx;
		logic shift;
		logic [HistCntW-1:0] shift_n;
		logic [15:0] wx;
		logic [15:0] wy;
	} cell_ctl_t;

	function automatic logic signed [AccW-1:0] atan_q16(input logic [StepW-1:0] i);
		logic signed [AccW-1:0] r;
		unique case (i)
			4'd0: r = 40'sd2949120;
			4'd1: r = 40'sd1740967;
			4'd2: r = 40'sd919879;
			4'd3: r = 40'sd466945;
			4'd4: r = 40'sd234379;
			4'd5: r = 40'sd117280;
			4'd6: r = 40'sd58666;
			4'd7: r = 40'sd29335;
			4'd8: r = 40'sd14668;
			4'd9: r = 40'sd7334;
			4'd10: r = 40'sd3667;
			4'd11: r = 40'sd1833;
			4'd12: r = 40'sd917;
			4'd13: r = 40'sd458;
			4'd14: r = 40'sd229;
			default: r = 40'sd115;
		endcase
		return r;
	endfunction
endpackage

@@ rtl/ttk_cell.sv @@
// ----------------------------------------------------------------------------
// ttk_cell
// One history slot: loads a new position or takes its upper neighbour's.
// ----------------------------------------------------------------------------
module ttk_cell (
	input logic clk,
	input ttk_pkg::cell_ctl_t ctl,
	input logic [ttk_pkg::HistIdxW-1:0] my_idx,
	input logic [15:0] nb_x,
	input logic [15:0] nb_y,
	output logic [15:0] px,
	output logic [15:0] py
);
	import ttk_pkg::*;
	logic [15:0] x_q, y_q;
	logic [HistCntW-1:0] idx_w;
	assign idx_w = {1'b0, my_idx};
	always_ff @(posedge clk) begin
		if (ctl.wr && ctl.wr_idx == my_idx) begin
			x_q <= ctl.wx;
			y_q <= ctl.wy;
		end else if (ctl.shift && idx_w < ctl.shift_n) begin
			x_q <= nb_x;
			y_q <= nb_y;
		end
	end
	assign px = x_q;
	assign py = y_q;
endmodule

@@ rtl/ttk_chain.sv @@
// ----------------------------------------------------------------------------
// ttk_chain
// Row of history cells with a single registered read port.
// ----------------------------------------------------------------------------
module ttk_chain (
	input logic clk,
	input ttk_pkg::cell_ctl_t ctl,
	input logic [ttk_pkg::HistIdxW-1:0] rd_idx,
	output logic [15:0] rd_x,
	output logic [15:0] rd_y
);
	import ttk_pkg::*;
	logic [15:0] cx [HistDepth];
	logic [15:0] cy [HistDepth];
	logic [15:0] rx_q, ry_q;
	for (genvar g = 0; g < HistDepth; g++) begin : g_cell
		localparam int Nb = (g + 1 < HistDepth) ? g + 1 : g;
		ttk_cell u_cell (
			.clk(clk), .ctl(ctl), .my_idx(HistIdxW'(g)),
			.nb_x(cx[Nb]), .nb_y(cy[Nb]), .px(cx[g]), .py(cy[g])
		);
	end
	always_ff @(posedge clk) begin
		rx_q <= cx[rd_idx];
		ry_q <= cy[rd_idx];
	end
	assign rd_x = rx_q;
	assign rd_y = ry_q;
endmodule

@@ rtl/ttk_cordic.sv @@
// ----------------------------------------------------------------------------
// ttk_cordic
// Iterative CORDIC vectoring, one micro-rotation per cycle, degrees Q9.7 out.
// ----------------------------------------------------------------------------
module ttk_cordic (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [16:0] dx,
	input logic signed [16:0] dy,
	output logic done,
	output logic signed [15:0] angle
);
	import ttk_pkg::*;
	logic signed [AccW-1:0] x_q, y_q, z_q, xs, ys, zr, q;
	logic [StepW-1:0] i_q;
	logic busy_q, done_q;
	logic signed [15:0] ang_q;
	logic signed [AccW-1:0] dxe, dye;
	assign dxe = AccW'(dx) <<< 14;
	assign dye = AccW'(dy) <<< 14;
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	always_comb begin
		zr = z_q[AccW-1] ? -z_q : z_q;
		q = (zr + AccW'(256)) >>> 9;
		if (q > AccW'(HalfTurnQ7)) q = AccW'(HalfTurnQ7);
		if (z_q[AccW-1]) q = -q;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				if (i_q == StepW'(CordicSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				i_q <= i_q + 1'b1;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			if (dx == 0 && dy == 0) begin
				x_q <= '0;
				y_q <= '0;
				z_q <= '0;
			end else if (dx < 0) begin
				x_q <= -dxe;
				y_q <= -dye;
				z_q <= (dy >= 0) ? HalfTurnQ16 : -HalfTurnQ16;
			end else begin
				x_q <= dxe;
				y_q <= dye;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (x_q == 0 && y_q == 0 && z_q == 0) begin
				z_q <= '0;
			end else if (!y_q[AccW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_q16(i_q);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_q16(i_q);
			end
		end
		if (busy_q && i_q == StepW'(CordicSteps - 1)) ang_q <= '0;
		if (done_q) ang_q <= q[15:0];
	end
	assign done = done_q;
	assign angle = ang_q;
endmodule

@@ rtl/target_track_keeper_core.sv @@
// ----------------------------------------------------------------------------
// target_track_keeper_core
// Single-target tracker: event state update, shifting history, CORDIC heading.
// ----------------------------------------------------------------------------
// channel | signals                                   | transfer when
// in      | in_valid, in_stall, func, pos_x/y, radius | in_valid & !in_stall
// out     | out_valid, out_stall, result fields       | out_valid & !out_stall
// cfg     | cfg_we, cfg_idx, cfg_data                 | cfg_we
// An event passes ST_SHIFT and then ST_OUT, with ST_FETCH, ST_CORDIC (the
// 16-step CORDIC iteration) and ST_ROUND between them when a heading is
// computed. One event is in flight at a time.
// Reset is asynchronous; no clearing pass. A stalled result holds in its
// output register; the next event is taken once it has gone.
// ----------------------------------------------------------------------------
`include "target_track_keeper_core_defines.svh"
module target_track_keeper_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] func,
	input logic signed [15:0] pos_x,
	input logic signed [15:0] pos_y,
	input logic [15:0] seen_radius,
	output logic out_valid,
	input logic out_stall,
	output logic is_active,
	output logic just_armed,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic [15:0] out_radius,
	output logic signed [15:0] heading,
	output logic [6:0] history_count,
	input logic cfg_we,
	input logic [2:0] cfg_idx,
	input logic [15:0] cfg_data
);
	import ttk_pkg::*;

	logic [6:0] hlen_q, dwin_q;
	logic [7:0] quick_q, slow_q, lost_q;
	logic [15:0] rest_q, radius_q;
	logic signed [15:0] x_q, y_q, head_q;
	logic active_q, armed_q, ov_q;
	logic [HistCntW-1:0] cnt_q;
	state_t st_q, st_d;
	cell_ctl_t ctl;
	logic [HistIdxW-1:0] rd_idx, ia_q, ib_q;
	logic [1:0] fphase_q;
	logic [15:0] rd_x, rd_y, ax_q, ay_q;
	logic cstart, cdone;
	logic signed [15:0] cang;
	logic [HistCntW-1:0] lim, win, shn_q;
	logic signed [15:0] park;

	assign park = (rest_q > 16'd32768) ? 16'sh8000 : -$signed(rest_q);
	always_comb begin
		lim = (hlen_q > 7'(HistDepth)) ? HistCntW'(HistDepth) : HistCntW'(hlen_q);
		if (lim < HistCntW'(2)) lim = HistCntW'(2);
		win = (HistCntW'(dwin_q) > cnt_q) ? cnt_q : HistCntW'(dwin_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hlen_q <= 7'd32;
			dwin_q <= 7'd8;
			quick_q <= 8'd5;
			slow_q <= 8'd30;
			rest_q <= 16'd160;
		end else if (cfg_we) begin
			priority case (cfg_idx)
				REG_HIST_LEN: hlen_q <= cfg_data[6:0];
				REG_DIR_WIN: dwin_q <= cfg_data[6:0];
				REG_QUICK: quick_q <= cfg_data[7:0];
				REG_SLOW: slow_q <= cfg_data[7:0];
				REG_REST: rest_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = (st_q != ST_IDLE);
	logic acc;
	assign acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		cstart = 1'b0;
		unique case (st_q)
			ST_IDLE: if (acc) st_d = ST_SHIFT;
			ST_SHIFT: st_d = (cnt_q > HistCntW'(1)) ? ST_FETCH : ST_OUT;
			ST_FETCH: if (fphase_q == 2'd2) begin
				st_d = ST_CORDIC;
				cstart = 1'b1;
			end
			ST_CORDIC: if (cdone) st_d = ST_ROUND;
			ST_ROUND: st_d = ST_OUT;
			ST_OUT: if (!ov_q) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// event update happens on accept; history shift in ST_SHIFT
	logic [HistCntW-1:0] cnt_inc;
	assign cnt_inc = cnt_q + 1'b1;
	always_comb begin
		ctl = '0;
		ctl.wx = pos_x;
		ctl.wy = pos_y;
		ctl.wr_idx = cnt_q[HistIdxW-1:0];
		if (acc && func == FUNC_DETECT && cnt_q < HistCntW'(HistDepth)) ctl.wr = 1'b1;
		if (st_q == ST_SHIFT && shn_q != '0) begin
			ctl.shift = 1'b1;
			ctl.shift_n = shn_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			x_q <= -16'sd160;
			y_q <= -16'sd160;
			radius_q <= 16'd160;
			active_q <= 1'b0;
			armed_q <= 1'b0;
			lost_q <= '0;
			head_q <= '0;
			shn_q <= '0;
			fphase_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (out_valid && !out_stall) ov_q <= 1'b0;
			if (st_q == ST_SHIFT) shn_q <= '0;
			if (acc) begin
				priority case (func)
					FUNC_SELECT: begin
						x_q <= pos_x;
						y_q <= pos_y;
						active_q <= 1'b1;
						armed_q <= 1'b1;
						cnt_q <= '0;
					end
					FUNC_DETECT: begin
						armed_q <= 1'b0;
						radius_q <= seen_radius;
						x_q <= pos_x;
						y_q <= pos_y;
						lost_q <= '0;
						if (cnt_inc >= lim) begin
							cnt_q <= lim - 1'b1;
							shn_q <= lim - 1'b1;
						end else cnt_q <= cnt_inc;
					end
					FUNC_MISS: begin
						shn_q <= cnt_q;
						if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
						if ((lost_q == 8'hFF ? lost_q : lost_q + 1'b1) >
							(armed_q ? quick_q : slow_q)) begin
							active_q <= 1'b0;
							armed_q <= 1'b0;
							lost_q <= '0;
							radius_q <= rest_q;
							cnt_q <= '0;
							head_q <= '0;
							x_q <= park;
							y_q <= park;
						end else begin
							if (lost_q != 8'hFF) lost_q <= lost_q + 1'b1;
							if (armed_q) begin
								x_q <= park;
								y_q <= park;
							end else if (radius_q != 16'hFFFF) radius_q <= radius_q + 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (st_q == ST_SHIFT) begin
				ia_q <= HistIdxW'(cnt_q - 1'b1);
				ib_q <= HistIdxW'(cnt_q - win);
				fphase_q <= '0;
			end
			if (st_q == ST_FETCH) begin
				fphase_q <= fphase_q + 1'b1;
				if (fphase_q == 2'd1) begin
					ax_q <= rd_x;
					ay_q <= rd_y;
				end
			end
			if (st_q == ST_ROUND) begin
				if (win < HistCntW'(2) || lost_q > 8'(LostHeadingLimit)) head_q <= '0;
				else head_q <= cang;
			end
			if (st_q != ST_OUT && st_d == ST_OUT) ov_q <= 1'b1;
		end
	end

	assign rd_idx = (st_q == ST_FETCH && fphase_q == 2'd0) ? ia_q : ib_q;

	ttk_chain u_chain (
		.clk(clk), .ctl(ctl), .rd_idx(rd_idx), .rd_x(rd_x), .rd_y(rd_y)
	);

	ttk_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cstart),
		.dx(17'($signed(ax_q)) - 17'($signed(rd_x))),
		.dy(17'($signed(ay_q)) - 17'($signed(rd_y))),
		.done(cdone), .angle(cang)
	);

	assign out_valid = ov_q && st_q == ST_OUT;
	assign is_active = active_q;
	assign just_armed = armed_q;
	assign out_x = x_q;
	assign out_y = y_q;
	assign out_radius = radius_q;
	assign heading = head_q;
	assign history_count = 7'(cnt_q);

	`TTK_ASSERT_IMP(a_armed_active, clk, arst_n, armed_q, active_q)
	`TTK_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q < HistCntW'(HistDepth))
	`TTK_ASSERT_NXT(a_out_holds, clk, arst_n, out_valid && out_stall, out_valid)
endmodule

@@ verif/target_track_keeper_core_test.sv @@
// ----------------------------------------------------------------------------
// target_track_keeper_core_test
// Self-checking bench: drives random frame events with random idling on both
// channels, predicts each result and checks every field, over several settings.
// ----------------------------------------------------------------------------
class track_scoreboard;
	int unsigned hist_len_reg, dir_win_reg, quick_reg, slow_reg, rest_reg;
	int hx[64], hy[64];
	int unsigned n_hist, lost;
	int cx, cy, hdg;
	int unsigned rad;
	bit active, armed;
	int fails;
	bit [72:0] exp_q[$];

	function void reset_state();
		hist_len_reg = 32; dir_win_reg = 8; quick_reg = 5; slow_reg = 30; rest_reg = 160;
		foreach (hx[i]) begin
			hx[i] = 0; hy[i] = 0;
		end
		n_hist = 0; lost = 0; active = 0; armed = 0; hdg = 0;
		cx = park(); cy = park(); rad = rest_reg;
	endfunction

	function int park();
		return (rest_reg > 32768) ? -32768 : -int'(rest_reg);
	endfunction

	function void write_reg(ttk_pkg::reg_idx_t idx, int unsigned v);
		case (idx)
			ttk_pkg::REG_HIST_LEN: hist_len_reg = v & 'h7f;
			ttk_pkg::REG_DIR_WIN: dir_win_reg = v & 'h7f;
			ttk_pkg::REG_QUICK: quick_reg = v & 'hff;
			ttk_pkg::REG_SLOW: slow_reg = v & 'hff;
			ttk_pkg::REG_REST: rest_reg = v & 'hffff;
			default: ;
		endcase
	endfunction

	function void drop_oldest(int unsigned n);
		for (int j = 0; j < n && j + 1 < 64; j++) begin
			hx[j] = hx[j+1]; hy[j] = hy[j+1];
		end
	endfunction

	function longint shr(longint v, int s);
		return v >>> s;
	endfunction

	function int atan_deg(int dx, int dy);
		longint x, y, z, q, xs, ys;
		longint tbl[16] = '{2949120, 1740967, 919879, 466945, 234379, 117280, 58666,
			29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
		if (dx == 0 && dy == 0) return 0;
		x = longint'(dx) * 16384; y = longint'(dy) * 16384; z = 0;
		if (x < 0) begin
			z = (y >= 0) ? 11796480 : -11796480;
			x = -x; y = -y;
		end
		for (int i = 0; i < 16; i++) begin
			xs = shr(x, i); ys = shr(y, i);
			if (y >= 0) begin
				x += ys; y -= xs; z += tbl[i];
			end else begin
				x -= ys; y += xs; z -= tbl[i];
			end
		end
		q = (z >= 0) ? ((z + 256) >>> 9) : -((-z + 256) >>> 9);
		if (q > 23040) q = 23040;
		if (q < -23040) q = -23040;
		return int'(q);
	endfunction

	function void release_if(int unsigned lim);
		if (lost > lim) begin
			active = 0; armed = 0; lost = 0; rad = rest_reg; n_hist = 0; hdg = 0;
			cx = park(); cy = park();
		end
	endfunction

	function void note_event(ttk_pkg::func_t f, int px, int py, int unsigned r);
		int unsigned lim, w;
		case (f)
			ttk_pkg::FUNC_SELECT: begin
				cx = px; cy = py; active = 1; armed = 1; n_hist = 0;
			end
			ttk_pkg::FUNC_DETECT: begin
				lim = (hist_len_reg > 64) ? 64 : (hist_len_reg < 2 ? 2 : hist_len_reg);
				armed = 0; rad = r; cx = px; cy = py; lost = 0;
				if (n_hist < 64) begin
					hx[n_hist] = px; hy[n_hist] = py;
				end
				n_hist++;
				if (n_hist >= lim) begin
					n_hist = lim - 1;
					drop_oldest(n_hist);
				end
			end
			ttk_pkg::FUNC_MISS: begin
				if (lost < 255) lost++;
				if (armed) begin
					cx = park(); cy = park();
				end
				drop_oldest(n_hist);
				if (n_hist > 0) n_hist--;
				if (armed) release_if(quick_reg);
				else begin
					if (rad < 'hffff) rad++;
					release_if(slow_reg);
				end
			end
			default: ;
		endcase
		if (n_hist > 1 && n_hist <= 64) begin
			w = (dir_win_reg > n_hist) ? n_hist : dir_win_reg;
			if (w < 2) hdg = 0;
			else hdg = atan_deg(hx[n_hist-1] - hx[n_hist-w], hy[n_hist-1] - hy[n_hist-w]);
			if (lost > 10) hdg = 0;
		end
		exp_q.push_back({active, armed, cx[15:0], cy[15:0], rad[15:0], hdg[15:0],
			n_hist[6:0]});
	endfunction

	function void check_result(bit [72:0] got);
		bit [72:0] e;
		if (exp_q.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			fails++;
			return;
		end
		e = exp_q.pop_front();
		if (e[72] !== got[72]) report("is_active", e[72], got[72]);
		if (e[71] !== got[71]) report("just_armed", e[71], got[71]);
		if (e[70:55] !== got[70:55]) report("out_x", e[70:55], got[70:55]);
		if (e[54:39] !== got[54:39]) report("out_y", e[54:39], got[54:39]);
		if (e[38:23] !== got[38:23]) report("out_radius", e[38:23], got[38:23]);
		if (e[22:7] !== got[22:7]) report("heading", e[22:7], got[22:7]);
		if (e[6:0] !== got[6:0]) report("history_count", e[6:0], got[6:0]);
	endfunction

	function void report(string what, int exp_v, int act_v);
		$display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
		fails++;
	endfunction
endclass

module target_track_keeper_core_test;
	import ttk_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] func = 0;
	logic signed [15:0] pos_x = 0, pos_y = 0;
	logic [15:0] seen_radius = 0;
	logic out_valid;
	logic out_stall = 0;
	logic is_active, just_armed;
	logic signed [15:0] out_x, out_y, heading;
	logic [15:0] out_radius;
	logic [6:0] history_count;
	logic cfg_we = 0;
	logic [2:0] cfg_idx = 0;
	logic [15:0] cfg_data = 0;

	track_scoreboard sb;
	int unsigned cycles = 0;
	int unsigned hold_off = 0;

	target_track_keeper_core DUT (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("Verification failed");
			$finish;
		end
	end

	function int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// result side: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({is_active, just_armed, out_x, out_y, out_radius, heading,
				history_count});
		if (hold_off > 0) begin
			out_stall <= 1;
			hold_off <= hold_off - 1;
		end else if (cycles % 300 < 100) out_stall <= 0;
		else out_stall <= ($urandom_range(0, 99) < 30);
	end

	// valid stays high after a transfer until the next gap or a drain
	task automatic send_event(func_t f, logic [15:0] px, logic [15:0] py, logic [15:0] r);
		int unsigned g;
		g = gap_len();
		if (cycles % 500 < 150) g = 0;
		cfg_we <= 0;
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1; func <= f; pos_x <= px; pos_y <= py; seen_radius <= r;
		do @(posedge clk); while (in_stall);
		sb.note_event(f, $signed(px), $signed(py), r);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.exp_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// write enable is lowered by the next event
	task automatic write_reg(reg_idx_t idx, logic [15:0] v);
		cfg_we <= 1; cfg_idx <= idx; cfg_data <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	task automatic rand_track(int unsigned len);
		logic [15:0] x, y, dx, dy;
		x = $urandom; y = $urandom;
		dx = $urandom_range(0, 255) - 128; dy = $urandom_range(0, 255) - 128;
		send_event(FUNC_SELECT, x, y, 0);
		for (int i = 0; i < len; i++) begin
			int unsigned r;
			r = $urandom_range(0, 99);
			if (r < 70) begin
				x = x + dx + $urandom_range(0, 15) - 8;
				y = y + dy + $urandom_range(0, 15) - 8;
				send_event(FUNC_DETECT, x, y, $urandom);
			end else if (r < 93) send_event(FUNC_MISS, $urandom, $urandom, $urandom);
			else if (r < 97) send_event(FUNC_NONE, $urandom, $urandom, $urandom);
			else send_event(func_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, each event kind, idle events, release paths
		send_event(FUNC_MISS, 0, 0, 0);
		send_event(FUNC_NONE, 16'hffff, 16'hffff, 16'hffff);
		send_event(FUNC_DETECT, 16'h7fff, 16'h8000, 16'hffff);
		send_event(FUNC_MISS, 0, 0, 0);
		send_event(FUNC_SELECT, 16'h8000, 16'h7fff, 0);
		send_event(FUNC_DETECT, 16'h8000, 16'h7fff, 16'hfffe);
		send_event(FUNC_DETECT, 16'h7fff, 16'h8000, 16'h0000);
		send_event(FUNC_DETECT, 16'h7fff, 16'h8000, 16'h1234);
		send_event(FUNC_MISS, 0, 0, 0);
		send_event(FUNC_MISS, 0, 0, 0);
		send_event(FUNC_SELECT, 16'h0100, 16'h0100, 0);
		repeat (7) send_event(FUNC_MISS, 0, 0, 0);
		send_event(FUNC_SELECT, 0, 0, 0);
		send_event(FUNC_DETECT, 0, 0, 16'hffff);
		send_event(FUNC_DETECT, 0, 0, 16'hffff);
		send_event(FUNC_MISS, 0, 0, 0);
		send_event(FUNC_NONE, 0, 0, 0);
		drain();

		// long receiver hold-off while the sender keeps offering
		hold_off = 200;
		rand_track(20);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_HIST_LEN, 2); write_reg(REG_DIR_WIN, 1);
					write_reg(REG_QUICK, 0); write_reg(REG_SLOW, 0);
					write_reg(REG_REST, 16'hffff);
				end
				1: begin
					write_reg(REG_HIST_LEN, 64); write_reg(REG_DIR_WIN, 64);
					write_reg(REG_QUICK, 254); write_reg(REG_SLOW, 254);
					write_reg(REG_REST, 0);
				end
				2: begin
					write_reg(REG_HIST_LEN, 127); write_reg(REG_DIR_WIN, 127);
					write_reg(REG_QUICK, 255); write_reg(REG_SLOW, 12);
					write_reg(REG_REST, 16'h8000);
				end
				3: begin
					write_reg(REG_HIST_LEN, 0); write_reg(REG_DIR_WIN, 0);
					write_reg(REG_QUICK, 3); write_reg(REG_SLOW, 8);
					write_reg(REG_REST, 16'h8001);
				end
				default: begin
					write_reg(REG_HIST_LEN, $urandom_range(1, 80));
					write_reg(REG_DIR_WIN, $urandom_range(0, 80));
					write_reg(REG_QUICK, $urandom_range(0, 20));
					write_reg(REG_SLOW, $urandom_range(0, 40));
					write_reg(REG_REST, $urandom);
				end
			endcase
			for (int t = 0; t < 5; t++) rand_track($urandom_range(5, 40));
			drain();
		end
		// lowering the limit below the current fill
		write_reg(REG_HIST_LEN, 64);
		write_reg(REG_SLOW, 254);
		send_event(FUNC_SELECT, 0, 0, 0);
		for (int i = 0; i < 20; i++) send_event(FUNC_DETECT, 16'(i * 33), 16'(-i * 17), 16'(i));
		drain();
		write_reg(REG_HIST_LEN, 4);
		rand_track(10);
		drain();
		if (sb.fails == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end
endmodule
